// ===== design/str_pkg.sv =====
// ----------------------------------------------------------------------------
// str_pkg
// Shared types and constants for the trapezoidal stepper ramp scheduler.
// ----------------------------------------------------------------------------
package str_pkg;

  localparam int unsigned DelayBits       = 16;
  localparam int unsigned SingleStepDelay = 1000;

  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_DECEL = 2'd2,
    PH_RUN   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_POST,
    ST_OUT
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic take_in;    // latch input item
    logic exec;       // run start or compare update
    logic div_start;  // load the divider
    logic div_step;   // one quotient bit
    logic post;       // finish pulse after divide
    logic load_out;   // capture result item
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;   // exec step found a ramp update
    logic div_done;
  } dp_stat_t;

endpackage

// ===== design/str_datapath.sv =====
// ----------------------------------------------------------------------------
// str_datapath
// Move state, position counter and a bit-serial signed divider.
// ----------------------------------------------------------------------------
module str_datapath
  import str_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  logic                 func_i,
  input  logic signed [31:0]   steps_i,
  input  logic [15:0]          first_delay_i,
  input  logic [15:0]          cruise_ticks_i,
  input  logic [30:0]          decel_steps_i,
  output logic                 accepted_o,
  output logic [15:0]          compare_interval_o,
  output logic                 pulse_enable_o,
  output logic                 moving_o,
  output logic                 direction_o,
  output logic signed [31:0]   position_o
);

  localparam logic [15:0] SsDelay = 16'(SingleStepDelay);

  logic        func_q;
  logic [31:0] steps_q;
  logic [15:0] first_q, min_q;
  logic [30:0] dlen_q;

  phase_e      phase_q, phase_d;
  logic        dir_q, dir_d;
  logic [15:0] cur_q, cur_d, cruise_q, cruise_d, last_q, last_d;
  logic [31:0] dbegin_q, dbegin_d, dinit_q, dinit_d, rcnt_q, rcnt_d;
  logic [31:0] done_q, done_d, rem_q, rem_d, pos_q, pos_d;
  logic        half_q, half_d, busy_q, busy_d;
  logic        acc_q, acc_d;
  logic [15:0] intv_q, intv_d;
  logic        need_q, need_d;

  // divider: unsigned restoring on magnitudes, 34-bit operands
  logic [33:0] dvd_q, dvs_q, rr_q;
  logic        qneg_q, rneg_q;
  logic [5:0]  cnt_q;
  logic [34:0] trial;

  logic [31:0] mag, dlen1, stp1, rc1;
  logic signed [33:0] num_s, den_s;

  // the ramp count has already advanced when the divide is loaded
  always_comb begin
    mag   = steps_q[31] ? (32'd0 - steps_q) : steps_q;
    dlen1 = (dlen_q == 31'd0) ? 32'd1 : {1'b0, dlen_q};
    stp1  = done_q + 32'd1;
    rc1   = rcnt_q + 32'd1;
    num_s = $signed({18'd0, cur_q} << 1) + 34'($signed(rem_q));
    den_s = ($signed(34'($signed(rcnt_q))) <<< 2) + 34'sd1;
    trial = {rr_q, dvd_q[33]} - {1'b0, dvs_q};
  end

  // quotient/remainder after the sweep
  logic [33:0] q_mag, q_s, r_s;
  logic [15:0] nd;
  always_comb begin
    q_mag = dvd_q;
    q_s   = qneg_q ? (34'd0 - q_mag) : q_mag;
    r_s   = rneg_q ? (34'd0 - rr_q) : rr_q;
    nd    = cur_q - q_s[15:0];
  end

  always_comb begin
    phase_d = phase_q; dir_d = dir_q; cur_d = cur_q; cruise_d = cruise_q;
    last_d = last_q; dbegin_d = dbegin_q; dinit_d = dinit_q; rcnt_d = rcnt_q;
    done_d = done_q; rem_d = rem_q; pos_d = pos_q; half_d = half_q;
    busy_d = busy_q; acc_d = acc_q; intv_d = intv_q; need_d = need_q;
    if (cmd_i.exec) begin
      acc_d = 1'b0; intv_d = '0; need_d = 1'b0;
      if (!func_q) begin
        if (!busy_q) begin
          dir_d = steps_q[31];
          if (mag == 32'd1) begin
            rcnt_d = '1; phase_d = PH_DECEL; cur_d = SsDelay;
          end else if (mag != 32'd0) begin
            cruise_d = min_q;
            dinit_d  = 32'd0 - dlen1;
            dbegin_d = (mag > dlen1) ? (mag - dlen1) : 32'd0;
            if (first_q <= min_q) begin
              cur_d = min_q; phase_d = PH_RUN;
            end else begin
              cur_d = first_q; phase_d = PH_ACCEL;
            end
            rcnt_d = '0;
          end
          busy_d = 1'b1; acc_d = 1'b1;
          intv_d = (mag == 32'd1) ? SsDelay : (mag == 32'd0) ? cur_q :
                   (first_q <= min_q) ? min_q : first_q;
        end
      end else if (busy_q) begin
        intv_d = cur_q;
        half_d = ~half_q;
        if (half_q) begin
          unique case (phase_q)
            PH_STOP: begin
              done_d = '0; rem_d = '0; busy_d = 1'b0; cur_d = '0;
            end
            PH_RUN: begin
              done_d = stp1;
              pos_d  = pos_q + (dir_q ? 32'hFFFF_FFFF : 32'd1);
              cur_d  = cruise_q;
              if (stp1 >= dbegin_q) begin
                rcnt_d = dinit_q; cur_d = last_q; phase_d = PH_DECEL;
              end
            end
            default: begin
              done_d = stp1;
              pos_d  = pos_q + (dir_q ? 32'hFFFF_FFFF : 32'd1);
              rcnt_d = rc1;
              need_d = 1'b1;
            end
          endcase
        end
      end
    end
    if (cmd_i.post) begin
      need_d = 1'b0;
      rem_d = r_s[31:0];
      cur_d = nd;
      if (phase_q == PH_ACCEL) begin
        if (done_q >= dbegin_q) begin
          rcnt_d = dinit_q; phase_d = PH_DECEL;
        end else if (nd <= cruise_q) begin
          last_d = nd; cur_d = cruise_q; rem_d = '0; phase_d = PH_RUN;
        end
      end else if (!rcnt_q[31]) begin
        phase_d = PH_STOP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STOP; dir_q <= 1'b0; cur_q <= '0; cruise_q <= '0;
      last_q <= '0; dbegin_q <= '0; dinit_q <= '0; rcnt_q <= '0;
      done_q <= '0; rem_q <= '0; pos_q <= '0; half_q <= 1'b0;
      busy_q <= 1'b0; acc_q <= 1'b0; intv_q <= '0; need_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      phase_q <= phase_d; dir_q <= dir_d; cur_q <= cur_d; cruise_q <= cruise_d;
      last_q <= last_d; dbegin_q <= dbegin_d; dinit_q <= dinit_d;
      rcnt_q <= rcnt_d; done_q <= done_d; rem_q <= rem_d; pos_q <= pos_d;
      half_q <= half_d; busy_q <= busy_d; acc_q <= acc_d; intv_q <= intv_d;
      need_q <= need_d;
      if (cmd_i.div_start)     cnt_q <= 6'd34;
      else if (cmd_i.div_step) cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      func_q <= func_i; steps_q <= steps_i; first_q <= first_delay_i;
      min_q <= cruise_ticks_i; dlen_q <= decel_steps_i;
    end
    if (cmd_i.div_start) begin
      dvd_q  <= num_s[33] ? (34'd0 - num_s) : num_s;
      dvs_q  <= den_s[33] ? (34'd0 - den_s) : den_s;
      rr_q   <= '0;
      qneg_q <= num_s[33] ^ den_s[33];
      rneg_q <= num_s[33];
    end else if (cmd_i.div_step) begin
      if (!trial[34]) rr_q <= trial[33:0];
      else            rr_q <= {rr_q[32:0], dvd_q[33]};
      dvd_q <= {dvd_q[32:0], ~trial[34]};
    end
    if (cmd_i.load_out) begin
      accepted_o <= acc_q; compare_interval_o <= intv_q;
      pulse_enable_o <= busy_q; moving_o <= busy_q;
      direction_o <= dir_q; position_o <= pos_q;
    end
  end

  assign stat_o.need_div = need_q;
  assign stat_o.div_done = (cnt_q == 6'd1);

endmodule

// ===== design/str_ctrl.sv =====
// ----------------------------------------------------------------------------
// str_ctrl
// Sequencer: takes an item, runs the update and, when needed, the divide, holds result.
// ----------------------------------------------------------------------------
module str_ctrl
  import str_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  output logic     valid_o,
  input  logic     ready_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ready_o = 1'b0;
    valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        ready_o = 1'b1;
        if (valid_i) begin
          cmd_o.take_in = 1'b1; state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1; state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!stat_i.need_div) begin
          cmd_o.load_out = 1'b1; state_d = ST_OUT;
        end else begin
          cmd_o.div_start = 1'b1; state_d = ST_POST;
        end
      end
      ST_POST: begin
        if (stat_i.div_done) begin
          cmd_o.div_step = 1'b1; state_d = ST_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_OUT: begin
        // first entry after divide finalises and returns to div to load, then holds the result
        valid_o = 1'b0;
        state_d = ST_OUT;
        if (stat_i.need_div) begin
          cmd_o.post = 1'b1; state_d = ST_DIV;
        end else begin
          valid_o = 1'b1;
          if (ready_i) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_DIV && stat_i.need_div) cmd_o.load_out = 1'b0;
  end

endmodule

// ===== design/stepper_trapezoid_ramp.sv =====
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp
// Trapezoidal stepper pulse scheduler with remainder-corrected ramp divide.
// ----------------------------------------------------------------------------
// Usage: one input transaction (func 0 start, func 1 compare event) yields
// exactly one result transaction. Both channels are valid/ready.
// Sequence: for a start, an idle event or a run/stop pulse the input is
// taken in idle, updated in exec, loaded in the div state and offered in
// out. When a pulse completes in accel or decel, div loads the 34-step
// bit-serial signed divider, post steps it, out finishes the pulse, div
// loads the result and out offers it.
// One item is in flight at a time; the next input is taken once the result
// has left.
// Reset: all move state clears, phase stop, position zero, no result held.
// Receiver stall: the result register holds its value with valid high and
// the block takes no new input until it is taken.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp
  import str_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               func_i,
  input  logic signed [31:0] steps_i,
  input  logic [15:0]        first_delay_i,
  input  logic [15:0]        cruise_ticks_i,
  input  logic [30:0]        decel_steps_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic               accepted_o,
  output logic [15:0]        compare_interval_o,
  output logic               pulse_enable_o,
  output logic               moving_o,
  output logic               direction_o,
  output logic signed [31:0] position_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  str_ctrl u_ctrl (
    .clk_i, .rst_ni, .valid_i, .ready_o, .valid_o, .ready_i,
    .cmd_o(cmd), .stat_i(stat)
  );

  // move state and divider
  str_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .func_i, .steps_i, .first_delay_i, .cruise_ticks_i, .decel_steps_i,
    .accepted_o, .compare_interval_o, .pulse_enable_o, .moving_o,
    .direction_o, .position_o
  );

endmodule

// ===== design/str_checker.sv =====
// ----------------------------------------------------------------------------
// str_checker
// Port-level checks for the stepper ramp scheduler.
// ----------------------------------------------------------------------------
module str_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        ready_o,
  input logic        valid_o,
  input logic        ready_i,
  input logic        accepted_o,
  input logic        pulse_enable_o,
  input logic        moving_o,
  input logic [31:0] position_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(position_o))
    else $error("result dropped while stalled");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(valid_o && ready_o))
    else $error("input taken while result pending");

  a_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> pulse_enable_o == moving_o)
    else $error("enable differs from moving");

  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && accepted_o |-> moving_o)
    else $error("accepted start not moving");

endmodule

bind stepper_trapezoid_ramp str_checker u_str_checker (
  .clk_i, .rst_ni, .ready_o, .valid_o, .ready_i,
  .accepted_o, .pulse_enable_o, .moving_o, .position_o
);
